// File: rtl/spac_pkg.sv
// package for the single particle acceptance cut: tables, codes and types
`default_nettype none
package spac_pkg;

	localparam int unsigned NUM_BINS  = 20;
	localparam int unsigned BIN_W     = 5;
	localparam int unsigned EDGE_W    = 20;
	localparam int unsigned EDGE_FRAC = 16;
	localparam int unsigned LIM_W     = 13;

	typedef logic [1:0] reason_t;
	localparam reason_t RSN_OK    = 2'd0;
	localparam reason_t RSN_RAPID = 2'd1;
	localparam reason_t RSN_PT    = 2'd2;
	localparam reason_t RSN_KIN   = 2'd3;

	// rapidity bin edges as q4.16 momentum ratio thresholds
	function automatic logic [EDGE_W-1:0] edge_at(input logic [BIN_W-1:0] k);
		logic [EDGE_W-1:0] v;
		begin
			case (k)
				5'd0: v = 20'd93935;
				5'd1: v = 20'd103814;
				5'd2: v = 20'd114732;
				5'd3: v = 20'd126799;
				5'd4: v = 20'd140134;
				5'd5: v = 20'd154872;
				5'd6: v = 20'd171160;
				5'd7: v = 20'd189161;
				5'd8: v = 20'd209055;
				5'd9: v = 20'd231042;
				5'd10: v = 20'd255341;
				5'd11: v = 20'd282195;
				5'd12: v = 20'd311874;
				5'd13: v = 20'd344674;
				5'd14: v = 20'd380924;
				5'd15: v = 20'd420986;
				5'd16: v = 20'd465261;
				5'd17: v = 20'd514193;
				5'd18: v = 20'd568272;
				5'd19: v = 20'd628037;
				5'd20: v = 20'd694089;
				default: v = '0;
			endcase
			return v;
		end
	endfunction

	// upper pt limit per bin, 1/16 MeV
	function automatic logic [LIM_W-1:0] pt_max_at(input logic [BIN_W-1:0] k);
		logic [LIM_W-1:0] v;
		begin
			case (k) inside
				5'd0, 5'd1: v = 13'd7040;
				5'd2, 5'd3: v = 13'd6400;
				5'd4: v = 13'd5760;
				5'd5, 5'd6: v = 13'd5120;
				5'd7, 5'd8: v = 13'd4480;
				5'd9, 5'd10: v = 13'd3840;
				5'd11, 5'd12, 5'd13: v = 13'd3200;
				5'd14, 5'd15: v = 13'd2560;
				5'd16, 5'd17, 5'd18: v = 13'd1920;
				default: v = 13'd1280;
			endcase
			return v;
		end
	endfunction

	// lower pt limit per bin, 1/16 MeV
	function automatic logic [LIM_W-1:0] pt_min_at(input logic [BIN_W-1:0] k);
		logic [LIM_W-1:0] v;
		begin
			case (k) inside
				5'd0: v = 13'd5120;
				5'd1: v = 13'd4480;
				5'd2, 5'd3: v = 13'd3840;
				5'd4: v = 13'd3200;
				5'd5, 5'd6: v = 13'd2560;
				5'd7, 5'd8: v = 13'd1920;
				5'd9, 5'd10, 5'd11, 5'd12: v = 13'd1280;
				5'd13, 5'd14, 5'd15: v = 13'd640;
				default: v = 13'd0;
			endcase
			return v;
		end
	endfunction

endpackage
`default_nettype wire

// File: rtl/spac_rap.sv
// rapidity path: ratio edge products, window test and bin pick over three stages
`default_nettype none
module spac_rap import spac_pkg::*; #(
	parameter int unsigned MB = 24
) (
	input  wire logic                   clk,
	input  wire logic                   vld,
	input  wire logic [MB-1:0]          energy,
	input  wire logic signed [MB-1:0]   mom_z,
	output logic                        kin_bad_s3,
	output logic                        win_bad_s3,
	output logic [BIN_W-1:0]            bin_s3
);
	localparam int unsigned SW = MB + 1;
	localparam int unsigned PW = SW + EDGE_W;
	localparam int unsigned NE = NUM_BINS + 1;

	logic [SW-1:0] plus_s1, minus_s1;
	logic          bad_s1;
	logic [NE-1:0] ge_s2;
	logic          gt_top_s2, bad_s2;

	// stage 1: e+pz and e-pz, validity
	always_ff @(posedge clk) begin
		logic signed [SW:0] p, m;
		p = $signed({2'b00, energy}) + {{2{mom_z[MB-1]}}, mom_z};
		m = $signed({2'b00, energy}) - {{2{mom_z[MB-1]}}, mom_z};
		if (vld) begin
			plus_s1  <= p[SW-1:0];
			minus_s1 <= m[SW-1:0];
			bad_s1   <= (p <= 0) || (m <= 0);
		end
	end

	// stage 2: compare ratio against every edge, one product each
	always_ff @(posedge clk) begin
		logic [PW-1:0] lhs, rhs;
		lhs = PW'({plus_s1, {EDGE_FRAC{1'b0}}});
		for (int k = 0; k < NE; k++) begin
			rhs = PW'(edge_at(BIN_W'(k))) * PW'(minus_s1);
			ge_s2[k] <= (lhs >= rhs);
		end
		rhs = PW'(edge_at(BIN_W'(NUM_BINS))) * PW'(minus_s1);
		gt_top_s2 <= lhs > rhs;
		bad_s2    <= bad_s1;
	end

	// stage 3: window and thermometer to bin
	always_ff @(posedge clk) begin
		logic [BIN_W-1:0] b;
		b = '0;
		for (int k = 1; k < NUM_BINS; k++)
			if (ge_s2[k]) b = BIN_W'(k);
		kin_bad_s3 <= bad_s2;
		win_bad_s3 <= !ge_s2[0] || gt_top_s2;
		bin_s3     <= b;
	end
endmodule
`default_nettype wire

// File: rtl/spac_pt.sv
// transverse momentum squared over three stages
`default_nettype none
module spac_pt import spac_pkg::*; #(
	parameter int unsigned MB = 24
) (
	input  wire logic                 clk,
	input  wire logic signed [MB-1:0] mom_x,
	input  wire logic signed [MB-1:0] mom_y,
	output logic [2*MB:0]             pt2_s3
);
	logic [MB-1:0]   ax_s1, ay_s1;
	logic [2*MB-1:0] sx_s2, sy_s2;

	// stage 1: magnitudes
	always_ff @(posedge clk) begin
		ax_s1 <= mom_x[MB-1] ? MB'(-mom_x) : MB'(mom_x);
		ay_s1 <= mom_y[MB-1] ? MB'(-mom_y) : MB'(mom_y);
	end

	// stage 2: squares
	always_ff @(posedge clk) begin
		sx_s2 <= (2*MB)'(ax_s1) * (2*MB)'(ax_s1);
		sy_s2 <= (2*MB)'(ay_s1) * (2*MB)'(ay_s1);
	end

	// stage 3: sum
	always_ff @(posedge clk) begin
		pt2_s3 <= {1'b0, sx_s2} + {1'b0, sy_s2};
	end
endmodule
`default_nettype wire

// File: rtl/single_particle_acceptance_cut.sv
// top level of the single particle acceptance cut
// Usage:
//  A particle word (energy, mom_x, mom_y, mom_z) is taken at a rising edge
//  where start is high and busy is low. busy is always low, so one word may
//  enter every cycle. Each word gives one result word (accept,
//  reject_reason, rapidity_bin) marked by done for one cycle: three stages
//  compute ratio edge tests and pt squared side by side, a fourth looks up
//  the bin limits and decides. Throughput is one word per cycle, set by the
//  fully pipelined edge multipliers (one per rapidity edge). The receiver
//  cannot hold results off; results are shown once and never repeated.
//  Reset clears only the valid pipeline, so no done appears after reset
//  until a new word is taken.
//  Invalid kinematics give reason 3, rapidity outside the window reason 1,
//  pt outside the bin limits reason 2 with the bin shown.
`default_nettype none
module single_particle_acceptance_cut import spac_pkg::*; #(
	parameter int unsigned MOMENTUM_BITS = 24
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            start,
	output logic                                 busy,
	input  wire logic [23:0]                     energy,
	input  wire logic signed [MOMENTUM_BITS-1:0] mom_x,
	input  wire logic signed [MOMENTUM_BITS-1:0] mom_y,
	input  wire logic signed [MOMENTUM_BITS-1:0] mom_z,
	output logic                                 done,
	output logic                                 accept,
	output reason_t                              reject_reason,
	output logic [BIN_W-1:0]                     rapidity_bin
);
	localparam int unsigned MB = (MOMENTUM_BITS > 24) ? MOMENTUM_BITS : 24;

	logic [2:0]         vld_q;
	logic               kin_bad_s3, win_bad_s3;
	logic [BIN_W-1:0]   bin_s3;
	logic [2*MB:0]      pt2_s3;
	logic [MB-1:0]      e_w;
	logic signed [MB-1:0] px_w, py_w, pz_w;

	assign busy = 1'b0;
	assign e_w  = MB'(energy);
	assign px_w = MB'(mom_x);
	assign py_w = MB'(mom_y);
	assign pz_w = MB'(mom_z);

	// valid bits along the stages
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
			done  <= 1'b0;
		end else begin
			vld_q <= {vld_q[1:0], start & ~busy};
			done  <= vld_q[2];
		end
	end

	spac_rap #(.MB(MB)) u_rap (
		.clk(clk), .vld(1'b1),
		.energy(e_w), .mom_z(pz_w),
		.kin_bad_s3(kin_bad_s3), .win_bad_s3(win_bad_s3), .bin_s3(bin_s3)
	);

	spac_pt #(.MB(MB)) u_pt (
		.clk(clk), .mom_x(px_w), .mom_y(py_w), .pt2_s3(pt2_s3)
	);

	// stage 4: limit lookup and decision
	always_ff @(posedge clk) begin
		logic [2*LIM_W-1:0] mx, mn;
		logic               acc;
		reason_t            rsn;
		logic [BIN_W-1:0]   bin;
		mx = (2*LIM_W)'(pt_max_at(bin_s3)) * (2*LIM_W)'(pt_max_at(bin_s3));
		mn = (2*LIM_W)'(pt_min_at(bin_s3)) * (2*LIM_W)'(pt_min_at(bin_s3));
		acc = 1'b0;
		rsn = RSN_OK;
		bin = '0;
		if (kin_bad_s3) begin
			rsn = RSN_KIN;
		end else if (win_bad_s3) begin
			rsn = RSN_RAPID;
		end else begin
			bin = bin_s3;
			if (pt2_s3 > (2*MB+1)'(mx) || pt2_s3 < (2*MB+1)'(mn)) begin
				rsn = RSN_PT;
			end else begin
				acc = 1'b1;
			end
		end
		accept        <= acc;
		reject_reason <= rsn;
		rapidity_bin  <= bin;
	end
endmodule
`default_nettype wire

// File: rtl/spac_checker.sv
// port level checker for the acceptance cut, bound to the top level
`default_nettype none
module spac_checker import spac_pkg::*; (
	input wire logic             clk,
	input wire logic             arst_n,
	input wire logic             start,
	input wire logic             busy,
	input wire logic             done,
	input wire logic             accept,
	input wire reason_t          reject_reason,
	input wire logic [BIN_W-1:0] rapidity_bin
);
	// a result follows every taken word
	a_lat: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##4 done) else $error("missing result");
	// no result without a taken word behind it
	a_nospur: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, 4)) else $error("spurious result");
	// accept agrees with reason
	a_acc: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (accept == (reject_reason == RSN_OK))) else $error("accept mismatch");
	// bin is zero on early rejects and in range otherwise
	a_bin: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (((reject_reason == RSN_KIN || reject_reason == RSN_RAPID)
		&& rapidity_bin == 0) || ((reject_reason == RSN_OK || reject_reason == RSN_PT)
		&& rapidity_bin < NUM_BINS))) else $error("bad bin");
endmodule

bind single_particle_acceptance_cut spac_checker u_chk (
	.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .done(done),
	.accept(accept), .reject_reason(reject_reason), .rapidity_bin(rapidity_bin)
);
`default_nettype wire

// File: sim/single_particle_acceptance_cut_test.sv
// testbench for the single particle acceptance cut: directed table, random words, scoreboard
`timescale 1ns / 100ps
`default_nettype none
module single_particle_acceptance_cut_test;
	import spac_pkg::*;

	typedef struct packed {
		logic           accept;
		reason_t        reason;
		logic [4:0]     bin;
	} verdict_t;

	typedef struct {
		logic [23:0]        e;
		logic signed [23:0] px, py, pz;
		logic               has_exp;
		verdict_t           exp_v;
	} row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	logic [23:0] energy = '0;
	logic signed [23:0] mom_x = '0, mom_y = '0, mom_z = '0;
	logic done, accept;
	reason_t reject_reason;
	logic [BIN_W-1:0] rapidity_bin;

	verdict_t pending_verdicts[$];
	int mismatches = 0;
	int words_sent = 0;
	int accepted_seen = 0;

	single_particle_acceptance_cut dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.energy(energy), .mom_x(mom_x), .mom_y(mom_y), .mom_z(mom_z),
		.done(done), .accept(accept), .reject_reason(reject_reason),
		.rapidity_bin(rapidity_bin)
	);

	// clock, 10 ns period
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	initial begin
		#20ms;
		$display("end of test: mismatches");
		$finish;
	end

	task automatic report(input string what);
		mismatches++;
		$display("%0t mismatch: %s", $time, what);
	endtask

	// acceptance decision for one particle word
	function automatic verdict_t judge_particle(input logic [23:0] e,
			input logic signed [23:0] px, input logic signed [23:0] py,
			input logic signed [23:0] pz);
		longint plus, minus, ax, ay, pt2, lo, hi;
		longint unsigned num;
		verdict_t v;
		v = '0;
		plus = longint'(e) + longint'(pz);
		minus = longint'(e) - longint'(pz);
		if (plus <= 0 || minus <= 0) begin
			v.reason = RSN_KIN;
			return v;
		end
		num = longint'(plus) << EDGE_FRAC;
		if (num < longint'(edge_at(5'd0)) * minus ||
				num > longint'(edge_at(5'd20)) * minus) begin
			v.reason = RSN_RAPID;
			return v;
		end
		for (int k = 1; k < NUM_BINS; k++)
			if (num >= longint'(edge_at(k[4:0])) * minus) v.bin = k[4:0];
		ax = px < 0 ? -longint'(px) : longint'(px);
		ay = py < 0 ? -longint'(py) : longint'(py);
		pt2 = ax * ax + ay * ay;
		hi = longint'(pt_max_at(v.bin));
		lo = longint'(pt_min_at(v.bin));
		if (pt2 > hi * hi || pt2 < lo * lo) v.reason = RSN_PT;
		else v.accept = 1'b1;
		return v;
	endfunction

	// check each result word against the oldest expectation
	always @(posedge clk) begin
		verdict_t want;
		if (arst_n && done) begin
			if (pending_verdicts.size() == 0) report("result with nothing expected");
			else begin
				want = pending_verdicts.pop_front();
				if (accept !== want.accept)
					report($sformatf("accept %b want %b", accept, want.accept));
				if (reject_reason !== want.reason)
					report($sformatf("reason %0d want %0d", reject_reason, want.reason));
				if (rapidity_bin !== want.bin)
					report($sformatf("bin %0d want %0d", rapidity_bin, want.bin));
				if (accept === 1'b1) accepted_seen++;
			end
		end
	end

	// issue one word, waiting for busy low
	task automatic send_word(input row_t r);
		verdict_t v;
		v = judge_particle(r.e, r.px, r.py, r.pz);
		if (r.has_exp && v !== r.exp_v) report("table row disagrees with predictor");
		start <= 1'b1;
		energy <= r.e; mom_x <= r.px; mom_y <= r.py; mom_z <= r.pz;
		@(posedge clk);
		while (busy) @(posedge clk);
		pending_verdicts.push_back(r.has_exp ? r.exp_v : v);
		words_sent++;
	endtask

	task automatic idle_burst();
		start <= 1'b0;
		repeat ($urandom_range(1, 14)) @(posedge clk);
	endtask

	// particle placed near a chosen bin edge with random pt, else noise
	function automatic row_t random_row(input int mode);
		row_t r;
		longint minus, plus, ed, pt;
		int k;
		r.has_exp = 1'b0;
		r.exp_v = '0;
		r.px = 24'($urandom); r.py = 24'($urandom);
		r.pz = 24'($urandom); r.e = 24'($urandom);
		if (mode < 7) begin
			k = $urandom_range(0, 20);
			minus = $urandom_range(1, 20000);
			ed = longint'(edge_at(k[4:0]));
			plus = (ed * minus) >>> 16;
			plus = plus + $signed($urandom_range(0, 4)) - 2;
			if (plus < 1) plus = 1;
			r.e = 24'((plus + minus) / 2);
			r.pz = 24'((plus - minus) / 2);
			pt = $urandom_range(0, 7600);
			r.px = 24'($signed($urandom_range(0, 1)) ? pt : -pt);
			r.py = 24'($signed($urandom_range(0, 400)) - 200);
			if ($urandom_range(0, 3) == 0) begin
				r.px = 24'(r.px * 7 / 10);
				r.py = r.px;
			end
		end
		return r;
	endfunction

	initial begin
		row_t tbl[$];
		row_t r;
		int limit;
		// directed rows: extremes, invalid kinematics, edges exactly
		r = '{24'd0, 0, 0, 0, 1, '{1'b0, RSN_KIN, 5'd0}}; tbl.push_back(r);
		r = '{24'hFFFFFF, 24'sh7FFFFF, 24'sh7FFFFF, 24'sh800000, 1,
			'{1'b0, RSN_RAPID, 5'd0}}; tbl.push_back(r);
		r = '{24'd100, 0, 0, 24'sd100, 1, '{1'b0, RSN_KIN, 5'd0}}; tbl.push_back(r);
		r = '{24'd100, 0, 0, -24'sd100, 1, '{1'b0, RSN_KIN, 5'd0}}; tbl.push_back(r);
		r = '{24'd1000, 0, 0, 0, 1, '{1'b0, RSN_RAPID, 5'd0}}; tbl.push_back(r);
		// ratio just under 3 lands in bin 7, huge pt fails it
		r = '{24'hFFFFFF, 24'sh800000, 24'sh800000, 24'sh7FFFFF, 1,
			'{1'b0, RSN_PT, 5'd7}}; tbl.push_back(r);
		r = '{24'hFFFFFF, -24'sd1, -24'sd1, 24'sh7FFFFF, 0, '{0, 0, 0}};
		tbl.push_back(r);
		// plus/minus exactly at edge 0 (minus = 131072) and above edge 20
		r = '{24'd159471, 24'sd5500, 0, 24'sd28399, 0, '{0, 0, 0}}; tbl.push_back(r);
		r = '{24'd759625, 24'sd1280, 0, 24'sd629553, 0, '{0, 0, 0}}; tbl.push_back(r);
		r = '{24'd759625, 24'sd1281, 0, 24'sd629553, 0, '{0, 0, 0}}; tbl.push_back(r);
		r = '{24'd759626, 0, 0, 24'sd629554, 0, '{0, 0, 0}}; tbl.push_back(r);
		r = '{24'd159471, 24'sd5119, 0, 24'sd28399, 0, '{0, 0, 0}}; tbl.push_back(r);
		r = '{24'd159471, 24'sd7040, 0, 24'sd28399, 0, '{0, 0, 0}}; tbl.push_back(r);
		r = '{24'd159471, 0, -24'sd7041, 24'sd28399, 0, '{0, 0, 0}}; tbl.push_back(r);
		r = '{24'd159470, 24'sd6000, 0, 24'sd28398, 0, '{0, 0, 0}}; tbl.push_back(r);

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (tbl[i]) send_word(tbl[i]);
		idle_burst();

		for (int n = 0; n < 1950; n++) begin
			if (n == 900) begin
				start <= 1'b0;
				while (pending_verdicts.size() != 0) @(posedge clk);
			end
			if (n < 1700 && $urandom_range(0, 5) == 0) idle_burst();
			send_word(random_row($urandom_range(0, 9)));
		end
		start <= 1'b0;

		limit = 0;
		while (pending_verdicts.size() != 0 && limit < 1000) begin
			@(posedge clk);
			limit++;
		end
		if (pending_verdicts.size() != 0)
			report($sformatf("%0d results never arrived", pending_verdicts.size()));
		repeat (10) @(posedge clk);

		$display("covered %0d particle words, %0d accepted, edges and invalid cases",
			words_sent, accepted_seen);
		if (mismatches == 0) $display("end of test: clean");
		else $display("end of test: mismatches");
		$finish;
	end
endmodule
`default_nettype wire
